// File: sv/mmts_pkg.sv
// ----------------------------------------------------------------------------
// mmts_pkg
// shared types, constants and helpers of the march memory test sequencer
// ----------------------------------------------------------------------------
package mmts_pkg;

    localparam int INDEX_BITS = 24;
    localparam int ADDR_W     = 32;
    localparam int DATA_W     = 32;
    localparam int WCOUNT_W   = 25;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_COUNT   = 2'd1;

    localparam logic [PHASE_W-1:0] PH_WRITE_ZERO   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ZERO_TO_ONES = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ONES_TO_PAT  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_PAT_TO_INV   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_INV_TO_ZERO  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_READ_ZERO    = 3'd5;

    localparam logic [DATA_W-1:0] MIX_MUL_A = 32'h9E3779B9;
    localparam logic [DATA_W-1:0] MIX_MUL_B = 32'h7FEB352D;
    localparam logic [DATA_W-1:0] MIX_XOR   = 32'hA5A55A5A;
    localparam logic [DATA_W-1:0] ALL_ONES  = 32'hFFFFFFFF;

    typedef enum logic {
        KIND_STEP,
        KIND_START
    } item_kind_t;

    typedef struct packed {
        item_kind_t        kind;
        logic [DATA_W-1:0] read_data;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   base_address;
        logic [WCOUNT_W-1:0] word_count;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  mem_address;
        logic [DATA_W-1:0]  write_data;
        logic               write_enable;
        logic               checked;
        logic               fail;
        logic [DATA_W-1:0]  expected;
        logic [DATA_W-1:0]  actual;
        logic [PHASE_W-1:0] phase;
        logic               done_res;
        logic [ADDR_W-1:0]  next_address;
    } result_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_COMMIT
    } bk_state_t;

    // index of the last word of the region, after the zero and size limits
    function automatic logic [INDEX_BITS-1:0] last_index(input logic [WCOUNT_W-1:0] wc);
        logic [ADDR_W:0] wide;
        logic [ADDR_W:0] limit;
        wide  = (ADDR_W + 1)'(wc);
        limit = (ADDR_W + 1)'(1) << INDEX_BITS;
        if (wc == '0)
            return '0;
        else if (wide > limit)
            return '1;
        else
            return INDEX_BITS'(wide - (ADDR_W + 1)'(1));
    endfunction

    function automatic logic [ADDR_W-1:0] word_addr(input logic [ADDR_W-1:0] base,
                                                    input logic [INDEX_BITS-1:0] idx);
        logic [ADDR_W-1:0] off;
        off = ADDR_W'(idx) << 2;
        return {base[ADDR_W-1:2], 2'b00} + off;
    endfunction

endpackage

// File: sv/mmts_front.sv
// ----------------------------------------------------------------------------
// mmts_front
// input register: takes items, tags start or step, hands them to the queue
// ----------------------------------------------------------------------------
module mmts_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       mode,
    input  logic [mmts_pkg::DATA_W-1:0] read_data,
    input  mmts_pkg::q_status_t        q_status,
    output logic                       push,
    output mmts_pkg::item_t            push_item
);
    import mmts_pkg::*;

    logic  hold_valid_reg;
    logic  hold_valid_next;
    item_t hold_item_reg;
    logic  accept;

    assign push     = hold_valid_reg && !q_status.full;
    assign in_stall = hold_valid_reg && q_status.full;
    assign accept   = in_valid && !in_stall;
    assign push_item = hold_item_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
            hold_valid_next = 1'b1;
        else if (push)
            hold_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_item_reg.kind      <= mode ? KIND_START : KIND_STEP;
            hold_item_reg.read_data <= read_data;
        end
    end

endmodule

// File: sv/mmts_queue.sv
// ----------------------------------------------------------------------------
// mmts_queue
// short fifo between the front register and the march sequencer
// ----------------------------------------------------------------------------
module mmts_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mmts_pkg::item_t     push_item,
    input  logic                pop,
    output mmts_pkg::item_t     pop_item,
    output mmts_pkg::q_status_t q_status
);
    import mmts_pkg::*;

    item_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign q_status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign pop_item       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !push || pop)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.empty |-> !pop)
        else $error("queue read while empty");
`endif

endmodule

// File: sv/mmts_back.sv
// ----------------------------------------------------------------------------
// mmts_back
// march sequencer: per item computes address and hash, checks, updates state
// ----------------------------------------------------------------------------
module mmts_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  mmts_pkg::cfg_t      cfg,
    input  mmts_pkg::q_status_t q_status,
    input  mmts_pkg::item_t     pop_item,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output mmts_pkg::result_t   result
);
    import mmts_pkg::*;

    bk_state_t              state_reg;
    bk_state_t              state_next;
    item_t                  item_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic [DATA_W-1:0]      iprod_reg;
    logic [DATA_W-1:0]      prod_reg;

    logic [PHASE_W-1:0]     current_phase_reg;
    logic [PHASE_W-1:0]     current_phase_next;
    logic [INDEX_BITS-1:0]  word_index_reg;
    logic [INDEX_BITS-1:0]  word_index_next;
    logic                   running_reg;
    logic                   running_next;
    logic                   failed_reg;
    logic                   failed_next;
    logic                   finished_reg;
    logic                   finished_next;

    logic                   out_valid_reg;
    result_t                result_reg;
    result_t                res;
    logic                   load;
    logic                   commit;

    logic [INDEX_BITS-1:0]  last_idx;
    logic [INDEX_BITS-1:0]  idx;
    logic [PHASE_W-1:0]     ph;
    logic [DATA_W-1:0]      mix;
    logic [DATA_W-1:0]      hash;
    logic [DATA_W-1:0]      exp_val;
    logic [DATA_W-1:0]      wdata;
    logic                   we;
    logic                   chk;
    logic                   up;
    logic                   mismatch;
    logic                   last;

    assign last_idx = last_index(cfg.word_count);
    assign idx      = (word_index_reg > last_idx) ? last_idx : word_index_reg;
    assign ph       = (current_phase_reg > PH_READ_ZERO) ? PH_READ_ZERO : current_phase_reg;
    assign mix      = addr_reg ^ iprod_reg;
    assign hash     = prod_reg ^ (prod_reg >> 15) ^ MIX_XOR;
    assign up       = (ph != PH_PAT_TO_INV) && (ph != PH_INV_TO_ZERO);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
                if (!q_status.empty)
                    state_next = BK_MUL;
            BK_MUL:
                state_next = BK_COMMIT;
            BK_COMMIT:
                if (!out_valid_reg || !out_stall)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // state machine outputs
    always_comb
    begin
        pop    = 1'b0;
        commit = 1'b0;
        unique case (state_reg)
            BK_IDLE:   pop = !q_status.empty;
            BK_MUL:    pop = 1'b0;
            BK_COMMIT: commit = !out_valid_reg || !out_stall;
            default:   pop = 1'b0;
        endcase
    end

    assign load = commit;

    // step decode and march state update
    always_comb
    begin
        exp_val  = '0;
        wdata    = '0;
        we       = 1'b0;
        chk      = 1'b0;
        unique case (ph)
            PH_WRITE_ZERO:   we = 1'b1;
            PH_ZERO_TO_ONES: begin chk = 1'b1; wdata = ALL_ONES; we = 1'b1; end
            PH_ONES_TO_PAT:  begin chk = 1'b1; exp_val = ALL_ONES; wdata = hash; we = 1'b1; end
            PH_PAT_TO_INV:   begin chk = 1'b1; exp_val = hash; wdata = ~hash; we = 1'b1; end
            PH_INV_TO_ZERO:  begin chk = 1'b1; exp_val = ~hash; we = 1'b1; end
            default:         chk = 1'b1;
        endcase
        mismatch = chk && (item_reg.read_data != exp_val);
        last     = up ? (idx == last_idx) : (idx == '0);

        current_phase_next = current_phase_reg;
        word_index_next    = word_index_reg;
        running_next       = running_reg;
        failed_next        = failed_reg;
        finished_next      = finished_reg;
        res                = '0;

        if (item_reg.kind == KIND_START)
        begin
            running_next       = 1'b1;
            failed_next        = 1'b0;
            finished_next      = 1'b0;
            current_phase_next = PH_WRITE_ZERO;
            word_index_next    = '0;
            res.phase          = PH_WRITE_ZERO;
            res.next_address   = word_addr(cfg.base_address, '0);
        end
        else if (!running_reg)
        begin
            res.phase = current_phase_reg;
        end
        else
        begin
            res.mem_address = addr_reg;
            res.phase       = ph;
            res.checked     = chk;
            if (chk)
            begin
                res.expected = exp_val;
                res.actual   = item_reg.read_data;
            end
            if (mismatch)
            begin
                failed_next        = 1'b1;
                running_next       = 1'b0;
                current_phase_next = ph;
                word_index_next    = idx;
            end
            else
            begin
                res.write_enable = we;
                res.write_data   = we ? wdata : '0;
                if (!last)
                begin
                    word_index_next    = up ? idx + 1'b1 : idx - 1'b1;
                    current_phase_next = ph;
                end
                else if (ph == PH_READ_ZERO)
                begin
                    finished_next      = 1'b1;
                    running_next       = 1'b0;
                    current_phase_next = PH_READ_ZERO;
                    word_index_next    = idx;
                end
                else
                begin
                    current_phase_next = ph + 1'b1;
                    // the pattern phase hands over at the top end for the downward pass
                    word_index_next    = (ph == PH_ONES_TO_PAT) ? last_idx : '0;
                end
                if (running_next)
                    res.next_address = word_addr(cfg.base_address, word_index_next);
            end
        end
        res.fail     = failed_next;
        res.done_res = finished_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= BK_IDLE;
            current_phase_reg <= '0;
            word_index_reg    <= '0;
            running_reg       <= 1'b0;
            failed_reg        <= 1'b0;
            finished_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                current_phase_reg <= current_phase_next;
                word_index_reg    <= word_index_next;
                running_reg       <= running_next;
                failed_reg        <= failed_next;
                finished_reg      <= finished_next;
            end
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath: first stage address and index product, second the hash multiply
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg  <= pop_item;
            addr_reg  <= word_addr(cfg.base_address, idx);
            iprod_reg <= DATA_W'(DATA_W'(idx) * MIX_MUL_A);
        end
        if (state_reg == BK_MUL)
            prod_reg <= DATA_W'((mix ^ (mix >> 16)) * MIX_MUL_B);
        if (load)
            result_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

`ifndef SYNTHESIS
    a_write_only_on_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result.write_enable && result.checked |-> result.expected == result.actual)
        else $error("write issued on a mismatching word");
    a_fail_done_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(failed_reg && finished_reg))
        else $error("march both failed and finished");
    a_running_clean: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> !failed_reg && !finished_reg)
        else $error("march running after an end condition");
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result.phase <= PH_READ_ZERO)
        else $error("reported phase out of range");
`endif

endmodule

// File: sv/march_memory_test_sequencer_top.sv
// ----------------------------------------------------------------------------
// march_memory_test_sequencer_top
// six-phase march memory self-test sequencer with register port
// ----------------------------------------------------------------------------
// Items enter an input register, pass a two-entry queue and are carried out
// one at a time by the march sequencer, which takes each through these steps:
// one for the word address and the index product, one for the hash multiply,
// one to check the read word, update the march and load the output register.
// The last step waits while the output register holds a stalled result, and a
// new item is taken from the queue only once the previous one is committed.
// Every item, start or step, gives exactly one result. Registers are written
// through the cfg port, which is always ready, and should only change while
// no item is in flight.
module march_memory_test_sequencer_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mmts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mmts_pkg::DATA_W-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           mode,
    input  logic [mmts_pkg::DATA_W-1:0]    read_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mmts_pkg::ADDR_W-1:0]    mem_address,
    output logic [mmts_pkg::DATA_W-1:0]    write_data,
    output logic                           write_enable,
    output logic                           checked,
    output logic                           fail,
    output logic [mmts_pkg::DATA_W-1:0]    expected,
    output logic [mmts_pkg::DATA_W-1:0]    actual,
    output logic [mmts_pkg::PHASE_W-1:0]   phase,
    output logic                           done_res,
    output logic [mmts_pkg::ADDR_W-1:0]    next_address
);
    import mmts_pkg::*;

    cfg_t      cfg_reg;
    q_status_t q_status;
    logic      push;
    item_t     push_item;
    logic      pop;
    item_t     pop_item;
    result_t   result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_address <= '0;
            cfg_reg.word_count   <= WCOUNT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BASE_ADDRESS: cfg_reg.base_address <= cfg_data;
                CFG_WORD_COUNT:   cfg_reg.word_count   <= cfg_data[WCOUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    mmts_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .read_data (read_data),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    mmts_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_status  (q_status)
    );

    mmts_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .pop_item  (pop_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    assign mem_address  = result.mem_address;
    assign write_data   = result.write_data;
    assign write_enable = result.write_enable;
    assign checked      = result.checked;
    assign fail         = result.fail;
    assign expected     = result.expected;
    assign actual       = result.actual;
    assign phase        = result.phase;
    assign done_res     = result.done_res;
    assign next_address = result.next_address;

endmodule

// File: verif/march_memory_test_sequencer_top_tb.sv
// ----------------------------------------------------------------------------
// march_memory_test_sequencer_top_tb
// self-checking bench for the six-phase march memory test sequencer
// ----------------------------------------------------------------------------
// A memory image answers each march step with the word last written at the
// announced address, or a random word if none was. A few reads are corrupted
// on purpose to trigger the fail path. Each accepted item is run through a
// local model of the march, and the resulting word is queued. Every result
// word from the block is checked field by field against the oldest queued
// word. Both sides idle and stall at random, and the region registers are
// reprogrammed between bursts once the block has drained.
module march_memory_test_sequencer_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mmts_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 12;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 mode;
    logic [DATA_W-1:0]    read_data;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [ADDR_W-1:0]    mem_address;
    logic [DATA_W-1:0]    write_data;
    logic                 write_enable;
    logic                 checked;
    logic                 fail;
    logic [DATA_W-1:0]    expected;
    logic [DATA_W-1:0]    actual;
    logic [PHASE_W-1:0]   phase;
    logic                 done_res;
    logic [ADDR_W-1:0]    next_address;

    // local copy of the region registers and march state
    logic [ADDR_W-1:0]     base_reg;
    logic [WCOUNT_W-1:0]   count_reg;
    logic [PHASE_W-1:0]    march_phase;
    logic [INDEX_BITS-1:0] march_index;
    bit                    march_running;
    bit                    march_failed;
    bit                    march_finished;

    logic [DATA_W-1:0] mem_image [logic [ADDR_W-1:0]];
    logic [ADDR_W-1:0] announced;
    result_t           march_results_q[$];

    int errors;
    int idle_pct;
    int stall_pct;
    int march_items;
    int quiet_cycles;

    march_memory_test_sequencer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .read_data    (read_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mem_address  (mem_address),
        .write_data   (write_data),
        .write_enable (write_enable),
        .checked      (checked),
        .fail         (fail),
        .expected     (expected),
        .actual       (actual),
        .phase        (phase),
        .done_res     (done_res),
        .next_address (next_address)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------------
    // march model
    // ------------------------------------------------------------------------

    function automatic int unsigned region_len();
        int unsigned n;
        n = count_reg;
        if (n == 0)
            n = 1;
        else if (n > (32'd1 << INDEX_BITS))
            n = 32'd1 << INDEX_BITS;
        return n;
    endfunction

    function automatic logic [ADDR_W-1:0] region_addr(input int unsigned i);
        return {base_reg[ADDR_W-1:2], 2'b00} + ADDR_W'(i << 2);
    endfunction

    function automatic logic [DATA_W-1:0] march_pattern(input logic [ADDR_W-1:0] a,
                                                        input int unsigned i);
        logic [DATA_W-1:0] x;
        x = a ^ (DATA_W'(i) * MIX_MUL_A);
        x = x ^ (x >> 16);
        x = x * MIX_MUL_B;
        x = x ^ (x >> 15);
        return x ^ MIX_XOR;
    endfunction

    function automatic result_t march_predict(input item_kind_t m, input logic [DATA_W-1:0] rd);
        result_t          r;
        int unsigned      n;
        int unsigned      i;
        logic [PHASE_W-1:0] ph;
        bit               up;
        bit               last;
        r = '0;
        n = region_len();
        if (m == KIND_START) begin
            march_running  = 1'b1;
            march_failed   = 1'b0;
            march_finished = 1'b0;
            march_phase    = PH_WRITE_ZERO;
            march_index    = '0;
            r.phase        = PH_WRITE_ZERO;
            r.next_address = region_addr(0);
        end
        else if (!march_running) begin
            r.phase = march_phase;
        end
        else begin
            i = march_index;
            if (i > n - 1)
                i = n - 1;
            ph = march_phase;
            if (ph > PH_READ_ZERO)
                ph = PH_READ_ZERO;
            r.phase        = ph;
            r.mem_address  = region_addr(i);
            up             = (ph != PH_PAT_TO_INV) && (ph != PH_INV_TO_ZERO);
            r.checked      = (ph != PH_WRITE_ZERO);
            r.write_enable = (ph != PH_READ_ZERO);
            case (ph)
                PH_ZERO_TO_ONES: r.write_data = ALL_ONES;
                PH_ONES_TO_PAT:
                begin
                    r.expected   = ALL_ONES;
                    r.write_data = march_pattern(r.mem_address, i);
                end
                PH_PAT_TO_INV:
                begin
                    r.expected   = march_pattern(r.mem_address, i);
                    r.write_data = ~r.expected;
                end
                PH_INV_TO_ZERO: r.expected = ~march_pattern(r.mem_address, i);
                default: ;
            endcase
            if (r.checked)
                r.actual = rd;
            if (r.checked && rd != r.expected) begin
                // first bad word stops the march where it is
                r.write_enable = 1'b0;
                r.write_data   = '0;
                march_failed   = 1'b1;
                march_running  = 1'b0;
                march_phase    = ph;
                march_index    = INDEX_BITS'(i);
            end
            else begin
                last = up ? (i == n - 1) : (i == 0);
                if (!last) begin
                    march_index = INDEX_BITS'(up ? i + 1 : i - 1);
                    march_phase = ph;
                end
                else if (ph == PH_READ_ZERO) begin
                    march_finished = 1'b1;
                    march_running  = 1'b0;
                    march_phase    = ph;
                    march_index    = INDEX_BITS'(i);
                end
                else begin
                    // the pattern phase hands over at the top end, every other phase at index zero
                    march_phase = ph + 3'd1;
                    march_index = INDEX_BITS'((ph == PH_ONES_TO_PAT) ? n - 1 : 0);
                end
                if (march_running)
                    r.next_address = region_addr(march_index);
            end
        end
        r.fail     = march_failed;
        r.done_res = march_finished;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (march_results_q.size() == 0) begin
                $display("%0t: result word with none expected, expected none actual %h",
                         $time, mem_address);
                errors++;
            end
            else begin
                want = march_results_q.pop_front();
                check_field("mem_address",  want.mem_address,  mem_address);
                check_field("write_data",   want.write_data,   write_data);
                check_field("write_enable", want.write_enable, write_enable);
                check_field("checked",      want.checked,      checked);
                check_field("fail",         want.fail,         fail);
                check_field("expected",     want.expected,     expected);
                check_field("actual",       want.actual,       actual);
                check_field("phase",        want.phase,        phase);
                check_field("done_res",     want.done_res,     done_res);
                check_field("next_address", want.next_address, next_address);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    task automatic send_item(input item_kind_t m, input logic [DATA_W-1:0] rd);
        result_t r;
        bit      was_running;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        read_data <= rd;
        do @(posedge clk); while (in_stall);
        was_running = march_running;
        r = march_predict(m, rd);
        march_results_q.push_back(r);
        if (r.write_enable)
            mem_image[r.mem_address] = r.write_data;
        announced = r.next_address;
        if (m == KIND_START || was_running)
            march_items++;
    endtask

    // one step answered from the memory image, now and then corrupted or restarted
    task automatic march_step(input int noise_pct);
        logic [DATA_W-1:0] rd;
        int                roll;
        rd   = mem_image.exists(announced) ? mem_image[announced] : DATA_W'($urandom);
        roll = $urandom_range(99);
        if (roll < noise_pct)
            send_item(KIND_STEP, rd ^ (32'h1 << $urandom_range(31)));
        else if (roll < noise_pct + noise_pct / 2)
            send_item(KIND_START, rd);
        else
            send_item(KIND_STEP, rd);
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (march_results_q.size() != 0);
    endtask

    task automatic cfg_word(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_BASE_ADDRESS: base_reg  = data;
            CFG_WORD_COUNT:   count_reg = data[WCOUNT_W-1:0];
            default: ;
        endcase
    endtask

    // registers only change with nothing in flight
    task automatic write_regs(input bit set_base, input logic [DATA_W-1:0] base_val,
                              input bit set_count, input logic [DATA_W-1:0] count_val);
        wait_results();
        if (set_base)
            cfg_word(CFG_BASE_ADDRESS, base_val);
        if (set_count)
            cfg_word(CFG_WORD_COUNT, count_val);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    task automatic test_steps_when_idle();
        send_item(KIND_STEP, '0);
        send_item(KIND_STEP, ALL_ONES);
        wait_results();
    endtask

    // zero count acts as one word, low base bits dropped, step after done
    task automatic test_one_word_march();
        write_regs(1'b1, 32'hFFFF_FFFF, 1'b1, 32'h0);
        send_item(KIND_START, ALL_ONES);
        repeat (6) march_step(0);
        send_item(KIND_STEP, 32'h1234_5678);
        wait_results();
    endtask

    // region wraps past the top of the address space, bad word mid phase 1
    task automatic test_mismatch_stops();
        write_regs(1'b1, 32'hFFFF_FFF8, 1'b1, 32'd3);
        send_item(KIND_START, '0);
        repeat (4) march_step(0);
        send_item(KIND_STEP, mem_image[announced] ^ 32'h8000_0000);
        send_item(KIND_STEP, ALL_ONES);
        wait_results();
    endtask

    // oversized count saturates, then shrinking it mid-march clamps the index
    task automatic test_count_limits();
        write_regs(1'b1, 32'h0, 1'b1, 32'h01FF_FFFF);
        send_item(KIND_START, '0);
        repeat (2) march_step(0);
        write_regs(1'b0, '0, 1'b1, 32'd1);
        repeat (2) march_step(0);
        wait_results();
    endtask

    task automatic test_random_marches(input int target);
        int                round;
        int                steps;
        bit                big;
        logic [DATA_W-1:0] base_val;
        logic [DATA_W-1:0] count_val;
        round       = 0;
        march_items = 0;
        while (march_items < target) begin
            big = ($urandom_range(9) == 0);
            case ($urandom_range(3))
                0: base_val = 32'h0;
                1: base_val = 32'hFFFF_FFFF - $urandom_range(31);
                default: base_val = $urandom;
            endcase
            if (big) begin
                case ($urandom_range(3))
                    0: count_val = 32'h0;
                    1: count_val = 32'd1 << INDEX_BITS;
                    2: count_val = 32'h01FF_FFFF;
                    default: count_val = $urandom;
                endcase
            end
            else begin
                count_val = $urandom_range(1, 6);
                // bits above the count field should be dropped
                if ($urandom_range(7) == 0)
                    count_val = count_val | ($urandom & 32'hFE00_0000);
            end
            write_regs(round == 0 || $urandom_range(3) != 0, base_val, 1'b1, count_val);

            // every fourth round of bursts runs with no idling on either side
            idle_pct  = (round % 4 == 2) ? 0 : 14;
            stall_pct = idle_pct;

            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(19) == 0)
                    send_item(KIND_STEP, $urandom);
                send_item(KIND_START, $urandom);
                steps = big ? $urandom_range(5, 25) : 6 * region_len() + $urandom_range(0, 2);
                repeat (steps) march_step(2);
            end
            round++;
        end
        wait_results();
    endtask

    initial begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_BASE_ADDRESS;
        cfg_data       = '0;
        in_valid       = 1'b0;
        mode           = KIND_STEP;
        read_data      = '0;
        base_reg       = '0;
        count_reg      = WCOUNT_W'(1);
        march_phase    = PH_WRITE_ZERO;
        march_index    = '0;
        march_running  = 1'b0;
        march_failed   = 1'b0;
        march_finished = 1'b0;
        announced      = '0;
        errors         = 0;
        idle_pct       = 14;
        stall_pct      = 14;
        march_items    = 0;
        quiet_cycles   = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_steps_when_idle();
        test_one_word_march();
        test_mismatch_stops();
        test_count_limits();
        test_random_marches(550);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (march_results_q.size() != 0) begin
            $display("%0t: result words missing, expected %0d actual 0", $time,
                     march_results_q.size());
            errors++;
        end
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
sv/mmts_pkg.sv
sv/mmts_front.sv
sv/mmts_queue.sv
sv/mmts_back.sv
sv/march_memory_test_sequencer_top.sv
verif/march_memory_test_sequencer_top_tb.sv
